// File: sv/wildcard_glob_matcher_top_defines.svh
// ----------------------------------------------------------------------------
// Wildcard glob matcher assertion macros
// Shared concurrent assertion forms for the matcher RTL.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_GLOB_MATCHER_TOP_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define WGM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wildcard matcher check failed");

// Next-cycle implication, disabled in reset.
`define WGM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wildcard matcher check failed");

`endif

// File: sv/wgm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Operation codes, special pattern characters and case folding.
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

   localparam int MAX_PATTERN_DEF = 32;

   localparam logic [7:0] CH_ANY  = 8'h3F;  // '?'
   localparam logic [7:0] CH_STAR = 8'h2A;  // '*'

   typedef enum logic [1:0] {
      OP_PATTERN = 2'd0,
      OP_SOURCE  = 2'd1,
      OP_END     = 2'd2
   } op_type;

   // fold A..Z to a..z, leave everything else
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/wildcard_glob_matcher_top.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher.
// Request channel (req_valid/req_ready) carries one word per item:
//   operation 0 appends a pattern character, 1 streams a source character,
//   2 ends the source. Char 0 pattern/source words are taken and ignored.
// Response channel (rsp_valid/rsp_ready) carries one word per end item:
//   rsp_matched and rsp_pattern_overflow.
// Pattern: '?' matches one character, '*' any run, others compare with
// ASCII case folding. Up to MAX_PATTERN characters are kept; more set the
// overflow flag. A new pattern starts with the first pattern word after
// any source or end word.
// Throughput: one word per cycle unless a held response blocks req_ready;
// the next active position vector is combinational (log-depth star closure).
// A response is registered, valid the cycle after its end word is accepted.
// A response held in the output register while rsp_ready is low deasserts
// req_ready; with rsp_ready high the next word is taken in the same cycle.
// Reset: pattern empty, active set at position zero, no response pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wildcard_glob_matcher_top_defines.svh"

module wildcard_glob_matcher_top
   import wgm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_character,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic       rsp_matched,
   output      logic       rsp_pattern_overflow
);

   localparam int POS_W = MAX_PATTERN + 1;
   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int LVL   = $clog2(POS_W);

   // pattern store: folded characters plus decoded flags
   logic [MAX_PATTERN-1:0][7:0] char_ff;
   logic [MAX_PATTERN-1:0]      star_ff;
   logic [MAX_PATTERN-1:0]      any_ff;

   logic [CNT_W-1:0] count_ff,   count_in;
   logic [POS_W-1:0] active_ff,  active_in;
   logic             loading_ff, loading_in;
   logic             overflow_ff, overflow_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             matched_ff, matched_in;
   logic             rsp_ov_ff,  rsp_ov_in;

   logic             accept;
   logic             char_nz;
   op_type           op;
   logic [7:0]       lc;
   logic [CNT_W-1:0] base_count;
   logic             wr_en;

   logic [MAX_PATTERN-1:0] pos_valid;
   logic [POS_W-1:0]       pos_le;
   logic [MAX_PATTERN-1:0] prop;
   logic [MAX_PATTERN-1:0] hitv;
   logic [LVL:0][POS_W-1:0] gen_l;
   logic [LVL:0][POS_W-1:0] prp_l;
   logic [POS_W-1:0]       cur;
   logic [POS_W-1:0]       next_set;
   logic [POS_W-1:0]       fin_sh;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign char_nz   = (req_character != 8'd0);
   assign op        = op_type'(req_operation);
   assign lc        = fold_case(req_character);

   // position decode against the fill count
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
      assign pos_valid[i] = (CNT_W'(i) < count_ff);
      assign prop[i]      = star_ff[i] && pos_valid[i];
      assign hitv[i]      = pos_valid[i] && !star_ff[i] && (any_ff[i] || (char_ff[i] == lc));
   end

   for (genvar j = 0; j < POS_W; j++) begin : g_le
      assign pos_le[j] = (CNT_W'(j) <= count_ff);
   end

   // star closure: a set bit runs up through consecutive active stars
   always_comb begin
      gen_l[0] = active_ff;
      prp_l[0] = {prop, 1'b0};
      for (int lv = 0; lv < LVL; lv++) begin
         gen_l[lv+1] = gen_l[lv] | (prp_l[lv] & (gen_l[lv] << (1 << lv)));
         prp_l[lv+1] = prp_l[lv] & (prp_l[lv] << (1 << lv));
      end
   end

   assign cur      = gen_l[LVL];
   assign next_set = {1'b0, cur[MAX_PATTERN-1:0] & prop}
                   | {cur[MAX_PATTERN-1:0] & hitv, 1'b0};
   assign fin_sh   = cur >> count_ff;

   assign base_count = loading_ff ? count_ff : '0;
   assign wr_en      = accept && (op == OP_PATTERN) && char_nz
                       && (base_count < CNT_W'(MAX_PATTERN));

   always_comb begin
      count_in     = count_ff;
      active_in    = active_ff;
      loading_in   = loading_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      matched_in   = matched_ff;
      rsp_ov_in    = rsp_ov_ff;
      if (accept) begin
         unique case (op)
            OP_PATTERN: begin
               if (char_nz) begin
                  loading_in = 1'b1;
                  active_in  = POS_W'(1);
                  if (base_count < CNT_W'(MAX_PATTERN)) begin
                     count_in    = base_count + CNT_W'(1);
                     overflow_in = loading_ff && overflow_ff;
                  end else begin
                     count_in    = base_count;
                     overflow_in = 1'b1;
                  end
               end
            end
            OP_SOURCE: begin
               if (char_nz) begin
                  loading_in = 1'b0;
                  active_in  = next_set;
               end
            end
            OP_END: begin
               loading_in   = 1'b0;
               active_in    = POS_W'(1);
               rsp_valid_in = 1'b1;
               matched_in   = fin_sh[0];
               rsp_ov_in    = overflow_ff;
            end
            default: begin
               // unused code: drop the word
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         active_ff    <= POS_W'(1);
         loading_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         active_ff    <= active_in;
         loading_ff   <= loading_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      rsp_ov_ff  <= rsp_ov_in;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (wr_en && (base_count == CNT_W'(k))) begin
            char_ff[k] <= lc;
            star_ff[k] <= (req_character == CH_STAR);
            any_ff[k]  <= (req_character == CH_ANY);
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = matched_ff;
   assign rsp_pattern_overflow = rsp_ov_ff;

   `WGM_ASSERT_IMP(a_ovf_full, clock, reset, overflow_ff, count_ff == CNT_W'(MAX_PATTERN))
   `WGM_ASSERT_NXT(a_end_rsp, clock, reset, accept && (op == OP_END), rsp_valid_ff)
   `WGM_ASSERT_NXT(a_pat_clr, clock, reset, accept && (op == OP_PATTERN) && char_nz,
                   active_ff == POS_W'(1) && loading_ff)
   `WGM_ASSERT_IMP(a_act_rng, clock, reset, 1'b1, (active_ff & ~pos_le) == '0)

endmodule

`default_nettype wire

// File: tb/tb_wildcard_glob_matcher_top.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher testbench
// Streams pattern, source and end words into the matcher and scores every
// verdict against an in-bench predictor of the active position set. Both
// channels idle at random: the sender in bursts, the receiver in stall modes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wildcard_glob_matcher_top;
   import wgm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXP = MAX_PATTERN_DEF;
   localparam int SET_W = MAXP + 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_operation;
   logic [7:0] req_character;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_matched;
   logic       rsp_pattern_overflow;

   // predictor state
   logic [7:0]  pat_mem [0:MAXP-1];
   int          pat_len = 0;
   logic [MAXP:0] live_set = SET_W'(1);
   bit          loading = 0;
   bit          dropped = 0;

   verdict_type verdict_q [$];
   logic [7:0]  pat_q [$];
   logic [7:0]  src_q [$];

   int errors = 0;
   int words_sent = 0;
   int words_ignored = 0;
   int verdicts_seen = 0;
   int matches_seen = 0;
   int overflows_seen = 0;
   int burst_left = 0;
   int cycle_count = 0;
   int rx_left = 0;
   rx_mode_type rx_mode = RX_OPEN;

   wildcard_glob_matcher_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_character        (req_character),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
   endfunction

   function automatic logic [7:0] swap_case(input logic [7:0] c);
      if (c >= "A" && c <= "Z") begin
         return c + 8'h20;
      end else if (c >= "a" && c <= "z") begin
         return c - 8'h20;
      end
      return c;
   endfunction

   // add the position after every live star, low to high so chains carry
   function automatic logic [MAXP:0] close_stars(input logic [MAXP:0] s);
      for (int i = 0; i < pat_len; i++) begin
         if (s[i] && pat_mem[i] == CH_STAR) s[i+1] = 1'b1;
      end
      return s;
   endfunction

   function automatic void apply_word(input logic [1:0] op, input logic [7:0] ch);
      logic [MAXP:0] cur;
      logic [MAXP:0] nxt;
      verdict_type v;
      case (op)
         OP_PATTERN: begin
            if (ch != 8'h00) begin
               if (!loading) begin
                  pat_len = 0;
                  dropped = 0;
                  loading = 1;
               end
               if (pat_len < MAXP) begin
                  pat_mem[pat_len] = ch;
                  pat_len++;
               end else begin
                  dropped = 1;
               end
               live_set = close_stars(SET_W'(1));
            end
         end
         OP_SOURCE: begin
            if (ch != 8'h00) begin
               loading = 0;
               cur = close_stars(live_set);
               nxt = '0;
               for (int i = 0; i < pat_len; i++) begin
                  if (cur[i]) begin
                     if (pat_mem[i] == CH_STAR) begin
                        nxt[i] = 1'b1;
                     end else if (pat_mem[i] == CH_ANY
                                  || to_lower(pat_mem[i]) == to_lower(ch)) begin
                        nxt[i+1] = 1'b1;
                     end
                  end
               end
               live_set = close_stars(nxt);
            end
         end
         OP_END: begin
            loading = 0;
            cur = close_stars(live_set);
            v.matched = cur[pat_len];
            v.overflow = dropped;
            verdict_q.push_back(v);
            live_set = close_stars(SET_W'(1));
         end
         default: ;
      endcase
   endfunction

   // drive one word; the sender takes a random gap between bursts
   task automatic send_word(input logic [1:0] op, input logic [7:0] ch);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_character <= ch;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (op == OP_RESERVED || (op != OP_END && ch == 8'h00)) begin
         words_ignored++;
      end else begin
         words_sent++;
      end
      apply_word(op, ch);
   endtask

   task automatic send_text(input logic [1:0] op, input string s);
      for (int i = 0; i < s.len(); i++) send_word(op, s[i]);
   endtask

   function automatic logic [7:0] pick_symbol(input bit wild);
      int r;
      r = $urandom_range(0, 15);
      if (wild && r <= 2) return CH_STAR;
      if (wild && r <= 4) return CH_ANY;
      if (r <= 7) return 8'($urandom_range(1, 255));
      case ($urandom_range(0, 4))
         0: return "a";
         1: return "b";
         2: return "A";
         3: return "B";
         default: return "c";
      endcase
   endfunction

   task automatic build_pattern(input int len);
      pat_q.delete();
      repeat (len) pat_q.push_back(pick_symbol(1));
   endtask

   // source that follows the stored prefix, sometimes nudged into a near miss
   task automatic build_match();
      int n;
      logic [7:0] c;
      src_q.delete();
      n = (pat_q.size() < MAXP) ? pat_q.size() : MAXP;
      for (int i = 0; i < n; i++) begin
         c = pat_q[i];
         if (c == CH_STAR) begin
            repeat ($urandom_range(0, 3)) src_q.push_back(pick_symbol(0));
         end else if (c == CH_ANY) begin
            src_q.push_back(8'($urandom_range(1, 255)));
         end else begin
            src_q.push_back($urandom_range(0, 1) ? swap_case(c) : c);
         end
      end
      if (src_q.size() != 0 && $urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1)) begin
            src_q.delete($urandom_range(0, src_q.size() - 1));
         end else begin
            src_q[$urandom_range(0, src_q.size() - 1)] = pick_symbol(0);
         end
      end
   endtask

   task automatic build_random_source(input int len);
      src_q.delete();
      repeat (len) src_q.push_back(pick_symbol(0));
   endtask

   task automatic play(input bit fresh, input bit close);
      if (fresh) begin
         foreach (pat_q[i]) send_word(OP_PATTERN, pat_q[i]);
      end
      foreach (src_q[i]) send_word(OP_SOURCE, src_q[i]);
      if (close) send_word(OP_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_directed();
      send_word(OP_END, 8'h00);              // empty pattern, empty source
      send_word(OP_SOURCE, "a");
      send_word(OP_END, 8'hFF);              // empty pattern, one byte
      send_word(OP_PATTERN, "*");
      send_word(OP_RESERVED, 8'h5A);
      send_word(OP_PATTERN, 8'h00);
      send_word(OP_END, 8'h80);              // lone star takes empty source
      send_text(OP_PATTERN, "*aab");
      send_text(OP_SOURCE, "aaab");
      send_word(OP_END, 8'h00);              // star has to back off
      send_text(OP_PATTERN, "A?");
      send_word(OP_PATTERN, 8'hFF);
      send_word(OP_SOURCE, "a");
      send_word(OP_SOURCE, 8'h00);
      send_word(OP_SOURCE, CH_STAR);
      send_word(OP_SOURCE, 8'hFF);
      send_word(OP_END, 8'h7F);
   endtask

   task automatic test_random_match();
      bit fresh;
      fresh = 1;
      while (words_sent < 850) begin
         if (fresh) begin
            build_pattern(($urandom_range(0, 4) == 0) ? $urandom_range(9, MAXP)
                                                       : $urandom_range(1, 8));
         end
         if ($urandom_range(0, 4) < 3) begin
            build_match();
         end else begin
            build_random_source($urandom_range(0, 10));
         end
         play(fresh, 1);
         fresh = ($urandom_range(0, 3) != 0);
      end
   endtask

   task automatic test_capacity();
      int lens [4];
      lens = '{MAXP, MAXP + 1, $urandom_range(MAXP + 2, MAXP + 8), MAXP - 1};
      foreach (lens[k]) begin
         build_pattern(lens[k]);
         build_match();
         play(1, 1);
         build_random_source($urandom_range(0, 3));
         play(0, 1);
      end
   endtask

   task automatic test_noise();
      while (words_sent < 1250) begin
         case ($urandom_range(0, 7))
            0: send_word(OP_RESERVED, 8'($urandom_range(0, 255)));
            1: send_word(2'($urandom_range(0, 1)), 8'h00);
            2: begin
               // source left open, until a later end word or new pattern takes over
               build_pattern($urandom_range(1, 6));
               build_random_source($urandom_range(1, 5));
               play(1, 0);
            end
            3: send_word(OP_END, 8'($urandom_range(0, 255)));
            4: begin
               build_pattern($urandom_range(1, 6));
               src_q.delete();
               play(1, 1);
            end
            default: begin
               build_pattern($urandom_range(1, 8));
               build_match();
               play(1, 1);
            end
         endcase
      end
   endtask

   // receiver stall pattern: open, coin toss or sparse
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_left = $urandom_range(40, 120);
         rx_mode = rx_mode_type'($urandom_range(0, 2));
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: verdict with none pending: matched=%0b overflow=%0b",
                     $time, rsp_matched, rsp_pattern_overflow);
            errors++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_matched !== want.matched) begin
               $display("%0t: matched expected %0b actual %0b",
                        $time, want.matched, rsp_matched);
               errors++;
            end
            if (rsp_pattern_overflow !== want.overflow) begin
               $display("%0t: pattern_overflow expected %0b actual %0b",
                        $time, want.overflow, rsp_pattern_overflow);
               errors++;
            end
            verdicts_seen++;
            if (want.matched) matches_seen++;
            if (want.overflow) overflows_seen++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d verdicts pending", $time, verdict_q.size());
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_PATTERN;
      req_character = 8'h00;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_match();
      test_capacity();
      test_noise();

      @(negedge clock);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d words plus %0d ignored ones over %0d cycles.",
               words_sent, words_ignored, cycle_count);
      $display("Checked %0d verdicts: %0d matches, %0d with overflow.",
               verdicts_seen, matches_seen, overflows_seen);
      if (errors == 0 && verdict_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/wgm_pkg.sv
sv/wildcard_glob_matcher_top.sv
tb/tb_wildcard_glob_matcher_top.sv
